@@ rtl/ert_pkg.sv @@
`default_nettype none
package ert_pkg;

  localparam int unsigned READER_SLOTS = 16;
  localparam int unsigned QUEUE_SLOTS  = 32;
  localparam int unsigned MAX_RESULTS  = 32;
  localparam int unsigned REL_CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam int unsigned ID_W     = 32;
  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned HANDLE_W = 48;
  localparam int unsigned STATUS_W = 3;

  // opcodes
  localparam logic [1:0] OP_ADD_READER = 2'd0;
  localparam logic [1:0] OP_DEL_READER = 2'd1;
  localparam logic [1:0] OP_QUEUE      = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NO_READER  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DUP_HANDLE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DUP_READER = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [EPOCH_W-1:0] epoch;
  } rd_entry_t;

  typedef struct packed {
    logic               add;
    logic               remove;
    logic [ID_W-1:0]    id;
    logic [EPOCH_W-1:0] epoch;
  } rd_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [EPOCH_W-1:0]  epoch;
  } q_entry_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [HANDLE_W-1:0] handle;
    logic [EPOCH_W-1:0]  epoch;
  } q_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/ert_if.sv @@
`default_nettype none
interface ert_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [ert_pkg::ID_W-1:0]     reader_id;
  logic [ert_pkg::HANDLE_W-1:0] node_handle;

  modport source (output valid, opcode, reader_id, node_handle, input ready);
  modport sink   (input valid, opcode, reader_id, node_handle, output ready);
endinterface

interface ert_out_if;
  logic                         valid;
  logic                         ready;
  logic [ert_pkg::STATUS_W-1:0] status;
  logic                         release_valid;
  logic [ert_pkg::HANDLE_W-1:0] released_handle;
  logic                         last;

  modport source (output valid, status, release_valid, released_handle, last,
                  input ready);
  modport sink   (input valid, status, release_valid, released_handle, last,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/ert_reader_cell.sv @@
`default_nettype none
module ert_reader_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ert_pkg::rd_ctrl_t  ctrl_i,
  input  wire logic               prev_valid_i,
  input  wire logic               after_i,
  input  wire ert_pkg::rd_entry_t next_i,
  output ert_pkg::rd_entry_t      entry_o,
  output logic                    hit_o,
  output logic                    after_o
);

  logic                        valid_q;
  logic [ert_pkg::ID_W-1:0]    id_q;
  logic [ert_pkg::EPOCH_W-1:0] epoch_q;
  logic                        load_new;
  logic                        shift;

  assign hit_o    = valid_q && (id_q == ctrl_i.id);
  assign after_o  = hit_o || after_i;
  assign load_new = ctrl_i.add && !valid_q && prev_valid_i;
  // close the gap left by a removed reader
  assign shift    = ctrl_i.remove && after_o;
  assign entry_o  = {valid_q, id_q, epoch_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_new) begin
      valid_q <= 1'b1;
    end else if (shift) begin
      valid_q <= next_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_new) begin
      id_q    <= ctrl_i.id;
      epoch_q <= ctrl_i.epoch;
    end else if (shift) begin
      id_q    <= next_i.id;
      epoch_q <= next_i.epoch;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ert_queue_cell.sv @@
`default_nettype none
module ert_queue_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ert_pkg::q_ctrl_t  ctrl_i,
  input  wire logic              prev_valid_i,
  input  wire ert_pkg::q_entry_t next_i,
  output ert_pkg::q_entry_t      entry_o,
  output logic                   hit_o
);

  logic                         valid_q;
  logic [ert_pkg::HANDLE_W-1:0] handle_q;
  logic [ert_pkg::EPOCH_W-1:0]  epoch_q;
  logic                         load_new;

  assign hit_o    = valid_q && (handle_q == ctrl_i.handle);
  assign load_new = ctrl_i.push && !valid_q && prev_valid_i;
  assign entry_o  = {valid_q, handle_q, epoch_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_new) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.pop) begin
      valid_q <= next_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_new) begin
      handle_q <= ctrl_i.handle;
      epoch_q  <= ctrl_i.epoch;
    end else if (ctrl_i.pop) begin
      handle_q <= next_i.handle;
      epoch_q  <= next_i.epoch;
    end
  end

endmodule
`default_nettype wire

@@ rtl/epoch_reclaim_tracker.sv @@
`default_nettype none
// Epoch-based reclamation tracker. Readers register with the current epoch
// and are kept in registration order in a row of reader cells; handles to be
// freed later are kept in a row of queue cells, head in the first cell. Add
// reader, remove reader and queue handle each give one item with a status. A
// tick gives one item per released handle (at most 32 per tick), or one
// empty result when nothing can go: the queue row shifts one cell per cycle
// toward its head while the output register is free, and that shift sets
// the release rate. A new item is taken only once the tick has finished and
// the output register is empty or being read in the same cycle; a result
// that waits on the output holds off the input.
module epoch_reclaim_tracker #(
  parameter int unsigned READER_SLOTS = ert_pkg::READER_SLOTS,
  parameter int unsigned QUEUE_SLOTS  = ert_pkg::QUEUE_SLOTS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ert_in_if.sink     in_i,
  ert_out_if.source  out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic state_q;

  // epoch counter and snapshot of the oldest reader taken at tick entry
  logic [ert_pkg::EPOCH_W-1:0] epoch_q;
  logic [ert_pkg::EPOCH_W-1:0] oldest_q;
  logic                        any_q;
  logic [ert_pkg::REL_CNT_W-1:0] rel_cnt_q;

  // output register
  logic                         out_vld_q;
  logic [ert_pkg::STATUS_W-1:0] status_q;
  logic                         rel_vld_q;
  logic [ert_pkg::HANDLE_W-1:0] handle_q;
  logic                         last_q;

  logic out_free;
  logic accept;
  logic out_load;

  ert_pkg::rd_entry_t rd_entry [READER_SLOTS];
  ert_pkg::rd_entry_t rd_next  [READER_SLOTS];
  logic [READER_SLOTS-1:0] rd_hit;
  logic [READER_SLOTS-1:0] rd_after;
  logic [READER_SLOTS-1:0] rd_vld_vec;
  ert_pkg::rd_ctrl_t rd_ctrl;

  ert_pkg::q_entry_t q_entry [QUEUE_SLOTS];
  ert_pkg::q_entry_t q_next  [QUEUE_SLOTS];
  logic [QUEUE_SLOTS-1:0] q_hit;
  logic [QUEUE_SLOTS-1:0] q_vld_vec;
  ert_pkg::q_ctrl_t q_ctrl;

  logic rd_dup, rd_full, q_dup, q_full;
  logic head_rel, next_rel, last_rel;
  logic [ert_pkg::STATUS_W-1:0] op_status;

  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept = in_i.valid && in_i.ready;
  // load the output register with a status item or one tick result
  assign out_load = (accept && (in_i.opcode != ert_pkg::OP_TICK))
                    || ((state_q == ST_TICK) && out_free);

  // reader row: cell 0 holds the oldest reader
  for (genvar i = 0; i < READER_SLOTS; i++) begin : g_rd
    logic prev_vld;
    logic prev_after;
    if (i == 0) begin : g_first
      assign prev_vld   = 1'b1;
      assign prev_after = 1'b0;
    end else begin : g_rest
      assign prev_vld   = rd_entry[i-1].valid;
      assign prev_after = rd_after[i-1];
    end
    if (i == READER_SLOTS - 1) begin : g_end
      assign rd_next[i] = '0;
    end else begin : g_mid
      assign rd_next[i] = rd_entry[i+1];
    end
    assign rd_vld_vec[i] = rd_entry[i].valid;

    ert_reader_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (rd_ctrl),
      .prev_valid_i (prev_vld),
      .after_i      (prev_after),
      .next_i       (rd_next[i]),
      .entry_o      (rd_entry[i]),
      .hit_o        (rd_hit[i]),
      .after_o      (rd_after[i])
    );
  end

  // queue row: cell 0 is the head, new handles land in the first free cell
  for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_q
    logic prev_vld;
    if (i == 0) begin : g_first
      assign prev_vld = 1'b1;
    end else begin : g_rest
      assign prev_vld = q_entry[i-1].valid;
    end
    if (i == QUEUE_SLOTS - 1) begin : g_end
      assign q_next[i] = '0;
    end else begin : g_mid
      assign q_next[i] = q_entry[i+1];
    end
    assign q_vld_vec[i] = q_entry[i].valid;

    ert_queue_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (q_ctrl),
      .prev_valid_i (prev_vld),
      .next_i       (q_next[i]),
      .entry_o      (q_entry[i]),
      .hit_o        (q_hit[i])
    );
  end

  assign rd_dup  = |rd_hit;
  assign rd_full = rd_entry[READER_SLOTS-1].valid;
  assign q_dup   = |q_hit;
  assign q_full  = q_entry[QUEUE_SLOTS-1].valid;

  always_comb begin
    rd_ctrl.add    = accept && (in_i.opcode == ert_pkg::OP_ADD_READER) && !rd_dup && !rd_full;
    rd_ctrl.remove = accept && (in_i.opcode == ert_pkg::OP_DEL_READER);
    rd_ctrl.id     = in_i.reader_id;
    rd_ctrl.epoch  = epoch_q;
  end

  // a handle may go when it is older than the oldest reader, or when no reader
  // was registered at tick entry
  assign head_rel = q_entry[0].valid && (!any_q || (q_entry[0].epoch < oldest_q));
  assign next_rel = q_next[0].valid && (!any_q || (q_next[0].epoch < oldest_q));
  assign last_rel = !next_rel
                    || (rel_cnt_q == ert_pkg::REL_CNT_W'(ert_pkg::MAX_RESULTS - 1));

  always_comb begin
    q_ctrl.push   = accept && (in_i.opcode == ert_pkg::OP_QUEUE) && !q_dup && !q_full;
    q_ctrl.pop    = (state_q == ST_TICK) && out_free && head_rel;
    q_ctrl.handle = in_i.node_handle;
    q_ctrl.epoch  = epoch_q;
  end

  always_comb begin
    op_status = ert_pkg::STS_OK;
    unique case (in_i.opcode)
      ert_pkg::OP_ADD_READER: begin
        if (rd_dup) begin
          op_status = ert_pkg::STS_DUP_READER;
        end else if (rd_full) begin
          op_status = ert_pkg::STS_FULL;
        end
      end
      ert_pkg::OP_DEL_READER: begin
        if (!rd_dup) begin
          op_status = ert_pkg::STS_NO_READER;
        end
      end
      ert_pkg::OP_QUEUE: begin
        if (q_dup) begin
          op_status = ert_pkg::STS_DUP_HANDLE;
        end else if (q_full) begin
          op_status = ert_pkg::STS_FULL;
        end
      end
      default: begin
        op_status = ert_pkg::STS_OK;
      end
    endcase
  end

  // control: state, epoch, tick snapshot, release count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      epoch_q   <= '0;
      any_q     <= 1'b0;
      rel_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (in_i.opcode == ert_pkg::OP_TICK)) begin
            state_q   <= ST_TICK;
            any_q     <= rd_entry[0].valid;
            rel_cnt_q <= '0;
            if (epoch_q != '1) begin
              epoch_q <= epoch_q + 1'b1;
            end
          end
        end
        ST_TICK: begin
          if (out_free) begin
            if (head_rel) begin
              rel_cnt_q <= rel_cnt_q + 1'b1;
              if (last_rel) begin
                state_q <= ST_IDLE;
              end
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload of the output register and the oldest-reader snapshot
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.opcode == ert_pkg::OP_TICK)) begin
      oldest_q <= rd_entry[0].epoch;
    end
    if (accept && (in_i.opcode != ert_pkg::OP_TICK)) begin
      status_q  <= op_status;
      rel_vld_q <= 1'b0;
      handle_q  <= '0;
      last_q    <= 1'b1;
    end else if ((state_q == ST_TICK) && out_free) begin
      status_q  <= ert_pkg::STS_OK;
      rel_vld_q <= head_rel;
      handle_q  <= head_rel ? q_entry[0].handle : '0;
      last_q    <= head_rel ? last_rel : 1'b1;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.status          = status_q;
  assign out_o.release_valid   = rel_vld_q;
  assign out_o.released_handle = handle_q;
  assign out_o.last            = last_q;

`ifndef SYNTHESIS
  a_no_accept_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> !in_i.ready)
    else $error("item taken while a tick is releasing");

  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && rel_vld_q) |-> (status_q == ert_pkg::STS_OK))
    else $error("release item carries a non-ok status");

  a_rel_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_cnt_q <= ert_pkg::REL_CNT_W'(ert_pkg::MAX_RESULTS))
    else $error("tick released too many handles");

  a_rd_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rd_vld_vec >> 1) & ~rd_vld_vec) == '0)
    else $error("reader row has a gap");

  a_q_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((q_vld_vec >> 1) & ~q_vld_vec) == '0)
    else $error("queue row has a gap");
`endif

endmodule
`default_nettype wire

@@ bench/epoch_reclaim_checker.sv @@
`default_nettype none
module epoch_reclaim_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ert_in_if         in_mon,
  ert_out_if        out_mon,
  output int        fail_count_o,
  output int        pending_count_o
);
  import ert_pkg::*;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [EPOCH_W-1:0] epoch;
  } reader_rec_t;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic [EPOCH_W-1:0]  epoch;
  } deferred_rec_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                release_valid;
    logic [HANDLE_W-1:0] released_handle;
    logic                last;
  } release_rec_t;

  logic [EPOCH_W-1:0] cur_epoch;
  reader_rec_t        readers[$];
  deferred_rec_t      deferred[$];
  release_rec_t       expected_releases[$];

  function automatic int reader_slot(logic [ID_W-1:0] id);
    foreach (readers[i]) if (readers[i].id == id) return i;
    return -1;
  endfunction

  function automatic void push_status(logic [STATUS_W-1:0] st);
    release_rec_t r;
    r.status = st; r.release_valid = 1'b0; r.released_handle = '0; r.last = 1'b1;
    expected_releases.insert(expected_releases.size(), r);
  endfunction

  // Advance the model by one accepted item and queue what it should emit.
  task automatic predict_releases(logic [1:0] op, logic [ID_W-1:0] id,
                                  logic [HANDLE_W-1:0] h);
    int                 pos;
    int                 n;
    bit                 dup;
    bit                 any_reader;
    logic [EPOCH_W-1:0] oldest;
    release_rec_t       r;
    reader_rec_t        rd;
    deferred_rec_t      dq;
    case (op)
      OP_ADD_READER: begin
        if (reader_slot(id) >= 0) push_status(STS_DUP_READER);
        else if (readers.size() >= READER_SLOTS) push_status(STS_FULL);
        else begin
          rd.id = id; rd.epoch = cur_epoch;
          readers.insert(readers.size(), rd);
          push_status(STS_OK);
        end
      end
      OP_DEL_READER: begin
        pos = reader_slot(id);
        if (pos < 0) push_status(STS_NO_READER);
        else begin
          readers.delete(pos);
          push_status(STS_OK);
        end
      end
      OP_QUEUE: begin
        dup = 1'b0;
        foreach (deferred[i]) if (deferred[i].handle == h) dup = 1'b1;
        if (dup) push_status(STS_DUP_HANDLE);
        else if (deferred.size() >= QUEUE_SLOTS) push_status(STS_FULL);
        else begin
          dq.handle = h; dq.epoch = cur_epoch;
          deferred.insert(deferred.size(), dq);
          push_status(STS_OK);
        end
      end
      default: begin
        any_reader = readers.size() > 0;
        oldest = any_reader ? readers[0].epoch : '0;
        if (cur_epoch != '1) cur_epoch = cur_epoch + 1'b1;
        n = 0;
        while (deferred.size() > 0 && n < MAX_RESULTS) begin
          if (any_reader && !(deferred[0].epoch < oldest)) break;
          r.status = STS_OK; r.release_valid = 1'b1;
          r.released_handle = deferred[0].handle; r.last = 1'b0;
          expected_releases.insert(expected_releases.size(), r);
          void'(deferred.pop_front());
          n++;
        end
        if (n == 0) push_status(STS_OK);
        else expected_releases[expected_releases.size()-1].last = 1'b1;
      end
    endcase
  endtask

  task automatic compare_release();
    release_rec_t e;
    if (expected_releases.size() == 0) begin
      $error("unexpected item: status=%0d handle=%h", out_mon.status,
             out_mon.released_handle);
      fail_count_o++;
      return;
    end
    e = expected_releases.pop_front();
    if (out_mon.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_mon.status);
      fail_count_o++;
    end
    if (out_mon.release_valid !== e.release_valid) begin
      $error("release_valid: expected %0d, got %0d", e.release_valid,
             out_mon.release_valid);
      fail_count_o++;
    end
    if (out_mon.released_handle !== e.released_handle) begin
      $error("released_handle: expected %h, got %h", e.released_handle,
             out_mon.released_handle);
      fail_count_o++;
    end
    if (out_mon.last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, out_mon.last);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_count_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_epoch = '0;
      readers.delete();
      deferred.delete();
      expected_releases.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) compare_release();
      if (in_mon.valid && in_mon.ready)
        predict_releases(in_mon.opcode, in_mon.reader_id, in_mon.node_handle);
    end
    pending_count_o = expected_releases.size();
  end
endmodule
`default_nettype wire

@@ bench/epoch_reclaim_tracker_tb.sv @@
`default_nettype none
module epoch_reclaim_tracker_tb;
  import ert_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int IDLE_LIMIT   = 5000;   // cycles with no item moving on either side
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off to back up the block

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  bit   burst_mode;     // when set, neither side inserts gaps

  ert_in_if  in_ch ();
  ert_out_if out_ch ();

  epoch_reclaim_tracker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  epoch_reclaim_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Small pools make duplicates, removals of live readers and repeated
  // handles common; the all-zero and all-one values sit in both pools.
  logic [ID_W-1:0]     id_pool[24];
  logic [HANDLE_W-1:0] handle_pool[48];

  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(0, 2);
  endfunction

  // Offer one item and hold it until the block takes it. Valid is lowered only
  // when a gap follows, so it never drops and rises in the same step.
  task automatic offer_item(logic [1:0] op, logic [ID_W-1:0] id,
                            logic [HANDLE_W-1:0] h);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.reader_id   <= id;
    in_ch.node_handle <= h;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic offer_random_item();
    int                  sel;
    logic [1:0]          op;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] h;
    sel = $urandom_range(0, 99);
    if (sel < 22)      op = OP_ADD_READER;
    else if (sel < 42) op = OP_DEL_READER;
    else if (sel < 78) op = OP_QUEUE;
    else               op = OP_TICK;
    id = $urandom_range(0, 9) == 0 ? $urandom() : id_pool[$urandom_range(0, 23)];
    h  = $urandom_range(0, 7) == 0 ? HANDLE_W'({$urandom(), $urandom()}) :
                                     handle_pool[$urandom_range(0, 47)];
    offer_item(op, id, h);
  endtask

  // Drain side: random ready gaps, one long hold-off partway through.
  initial begin : drain_side
    int  gap;
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && taken >= 120) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  // Watchdog: any item moving on either side resets the idle count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[epoch_reclaim_tracker] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : source_side
    int i;
    idle_cycles       = 0;
    burst_mode        = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_ADD_READER;
    in_ch.reader_id   = '0;
    in_ch.node_handle = '0;
    rst_ni            = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < 24; i++) id_pool[i] = $urandom();
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    for (i = 2; i < 48; i++) handle_pool[i] = HANDLE_W'({$urandom(), $urandom()});
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: duplicates, unknown reader, a blocked tick, then releases.
    offer_item(OP_ADD_READER, '0, '0);
    offer_item(OP_ADD_READER, '1, '0);
    offer_item(OP_ADD_READER, '0, '0);          // duplicate reader
    offer_item(OP_DEL_READER, 32'h1234_5678, '0); // unknown reader
    offer_item(OP_QUEUE, '0, '0);
    offer_item(OP_QUEUE, '0, '1);
    offer_item(OP_QUEUE, '0, '1);               // duplicate handle
    offer_item(OP_TICK, '0, '0);                // readers as old as handles: nothing
    offer_item(OP_DEL_READER, '0, '0);
    offer_item(OP_DEL_READER, '1, '0);
    offer_item(OP_TICK, '0, '0);                // no readers: release both
    offer_item(OP_TICK, '0, '0);                // empty queue

    // Fill the reader table past its size, then empty it again.
    for (i = 0; i <= READER_SLOTS; i++) offer_item(OP_ADD_READER, id_pool[i], '0);
    // Fill the queue past its size while readers pin every handle.
    for (i = 0; i <= QUEUE_SLOTS; i++) offer_item(OP_QUEUE, '0, handle_pool[i]);
    offer_item(OP_TICK, '0, '0);
    for (i = 0; i < READER_SLOTS; i++) offer_item(OP_DEL_READER, id_pool[i], '0);
    offer_item(OP_TICK, '0, '0);                // full burst of releases
    offer_item(OP_TICK, '0, '0);

    // Random part, in stretches with and without gaps, each chosen at random.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      offer_random_item();
    end
    burst_mode = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0)
      $display("[epoch_reclaim_tracker] OK");
    else
      $display("[epoch_reclaim_tracker] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
